// ===== src/rip_pkg.sv =====
// Package for the radix integer parser: character codes, mode and phase types,
// and the digit-decode struct shared by the decoder and the top level.
// No dependencies.
package rip_pkg;

  localparam int VALUE_WIDTH_DEF = 64;
  localparam int OUT_WIDTH       = 64;
  localparam int CH_WIDTH        = 8;

  localparam logic [CH_WIDTH-1:0] CH_NUL        = 8'h00;
  localparam logic [CH_WIDTH-1:0] CH_MINUS      = 8'h2D;
  localparam logic [CH_WIDTH-1:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [CH_WIDTH-1:0] CH_ZERO       = 8'h30;
  localparam logic [CH_WIDTH-1:0] CH_ONE        = 8'h31;
  localparam logic [CH_WIDTH-1:0] CH_SEVEN      = 8'h37;
  localparam logic [CH_WIDTH-1:0] CH_NINE       = 8'h39;
  localparam logic [CH_WIDTH-1:0] CH_UPPER_A    = 8'h41;
  localparam logic [CH_WIDTH-1:0] CH_UPPER_F    = 8'h46;
  localparam logic [CH_WIDTH-1:0] CH_LOWER_A    = 8'h61;
  localparam logic [CH_WIDTH-1:0] CH_LOWER_F    = 8'h66;

  typedef enum logic [1:0] {
    RADIX_DEC     = 2'd0,
    RADIX_DEC_OCT = 2'd1,
    RADIX_HEX     = 2'd2,
    RADIX_BIN     = 2'd3
  } radix_mode_t;

  typedef enum logic [1:0] {
    PH_SIGN   = 2'd0,
    PH_FIRST  = 2'd1,
    PH_DIGITS = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    BASE_2  = 2'd0,
    BASE_8  = 2'd1,
    BASE_10 = 2'd2,
    BASE_16 = 2'd3
  } base_sel_t;

  typedef struct packed {
    logic      is_digit;
    logic [3:0] digit;
    base_sel_t base_sel;
  } digit_t;

endpackage

// ===== src/rip_if.sv =====
// Channel interfaces of the radix integer parser: character input, value
// output and configuration write. Depends on rip_pkg.
interface rip_in_if
  import rip_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [CH_WIDTH-1:0] ch;
  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface rip_out_if
  import rip_pkg::*;
  ();
  logic                        valid;
  logic                        ready;
  logic signed [OUT_WIDTH-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface rip_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] radix_mode;
  modport source (output valid, output radix_mode, input ready);
  modport sink   (input valid, input radix_mode, output ready);
endinterface

// ===== src/rip_digit_dec.sv =====
// Digit decoder: classifies one character against the active radix and gives
// its digit value and the multiplier select. Depends on rip_pkg.
module rip_digit_dec
  import rip_pkg::*;
(
  input  logic [CH_WIDTH-1:0] ch,
  input  radix_mode_t         mode,
  input  logic                octal_active,
  output digit_t              dec
);

  logic [CH_WIDTH-1:0] off_num;
  logic [CH_WIDTH-1:0] off_upper;
  logic [CH_WIDTH-1:0] off_lower;
  logic                is_num;
  logic                is_upper;
  logic                is_lower;

  assign off_num   = ch - CH_ZERO;
  assign off_upper = ch - CH_UPPER_A + 8'd10;
  assign off_lower = ch - CH_LOWER_A + 8'd10;
  assign is_num    = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_upper  = (ch >= CH_UPPER_A) && (ch <= CH_UPPER_F);
  assign is_lower  = (ch >= CH_LOWER_A) && (ch <= CH_LOWER_F);

  always_comb begin
    dec.digit = off_num[3:0];
    unique case (mode)
      RADIX_HEX: begin
        dec.base_sel = BASE_16;
        dec.is_digit = is_num || is_upper || is_lower;
        if (is_upper) begin
          dec.digit = off_upper[3:0];
        end else if (is_lower) begin
          dec.digit = off_lower[3:0];
        end
      end
      RADIX_BIN: begin
        dec.base_sel = BASE_2;
        dec.is_digit = (ch == CH_ZERO) || (ch == CH_ONE);
      end
      default: begin
        // decimal modes; octal once a leading zero has been seen
        if (octal_active) begin
          dec.base_sel = BASE_8;
          dec.is_digit = (ch >= CH_ZERO) && (ch <= CH_SEVEN);
        end else begin
          dec.base_sel = BASE_10;
          dec.is_digit = is_num;
        end
      end
    endcase
  end

endmodule

// ===== src/radix_integer_parser_top.sv =====
// Top level of the radix integer parser: string state, multiply-add
// accumulator and output register. Depends on rip_pkg, rip_if, rip_digit_dec.
//
// The block takes one ASCII character per beat and returns one signed 64-bit
// value per string, on the zero character that ends it; other characters
// give no result. It accepts a character every clock cycle unless the output
// register holds a value that is not being taken. The string state and the
// accumulator are updated at the accepting edge, and the value of a terminated
// string appears in the output register in the cycle after its terminator
// beat. The accumulator loop is a constant multiply by 2, 8, 10 or 16 plus
// the digit. The output register decouples the sides:
// input is taken whenever the output register is empty or being drained in
// the same cycle. radix_mode (0 decimal, 1 decimal with leading-zero octal,
// 2 hex, 3 binary) is written through the cfg channel, which is always ready;
// write it only between strings. Underscores are skipped, a leading minus in
// the decimal modes negates the value, and the first unexpected character
// freezes the value until the terminator. The accumulator is VALUE_WIDTH bits
// wide and wraps; the result is sign-extended from bit VALUE_WIDTH-1.
module radix_integer_parser_top
  import rip_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  rip_in_if.sink      in_if,
  rip_out_if.source   out_if,
  rip_cfg_if.sink     cfg_if
);

  // configuration
  radix_mode_t mode_r;

  // string state
  logic [VALUE_WIDTH-1:0] acc_r, acc_nxt;
  logic                   neg_r, neg_nxt;
  phase_t                 phase_r, phase_nxt;
  logic                   oct_r, oct_nxt;
  logic                   halt_r, halt_nxt;

  // output register
  logic                        out_valid_r, out_valid_nxt;
  logic signed [OUT_WIDTH-1:0] value_r, value_nxt;

  logic                   in_acc;
  logic                   is_term;
  digit_t                 dec;
  logic [VALUE_WIDTH-1:0] acc_x2, acc_x8, acc_x16, acc_mul;
  logic [VALUE_WIDTH-1:0] acc_step;
  logic [VALUE_WIDTH-1:0] res;

  assign cfg_if.ready = 1'b1;

  // take a beat whenever the output slot is free or drains this cycle
  assign in_if.ready  = !out_valid_r || out_if.ready;
  assign in_acc       = in_if.valid && in_if.ready;
  assign is_term      = (in_if.ch == CH_NUL);

  assign out_if.valid = out_valid_r;
  assign out_if.value = value_r;

  // the registered octal flag is enough: the leading zero that sets it is a
  // zero digit in either radix and lands on an empty accumulator
  rip_digit_dec u_dec (
    .ch           (in_if.ch),
    .mode         (mode_r),
    .octal_active (oct_r),
    .dec          (dec)
  );

  // constant multiplies as shifts
  assign acc_x2  = {acc_r[VALUE_WIDTH-2:0], 1'b0};
  assign acc_x8  = {acc_r[VALUE_WIDTH-4:0], 3'b000};
  assign acc_x16 = {acc_r[VALUE_WIDTH-5:0], 4'b0000};

  always_comb begin
    unique case (dec.base_sel)
      BASE_2:  acc_mul = acc_x2;
      BASE_8:  acc_mul = acc_x8;
      BASE_10: acc_mul = acc_x8 + acc_x2;
      BASE_16: acc_mul = acc_x16;
    endcase
  end

  assign acc_step = acc_mul + VALUE_WIDTH'(dec.digit);

  // signed result of the string so far, wrapped to VALUE_WIDTH bits
  assign res = neg_r ? (VALUE_WIDTH'(0) - acc_r) : acc_r;

  always_comb begin
    acc_nxt       = acc_r;
    neg_nxt       = neg_r;
    phase_nxt     = phase_r;
    oct_nxt       = oct_r;
    halt_nxt      = halt_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    value_nxt     = value_r;

    if (in_acc) begin
      if (is_term) begin
        // emit and clear for the next string
        out_valid_nxt = 1'b1;
        value_nxt     = OUT_WIDTH'(signed'(res));
        acc_nxt       = '0;
        neg_nxt       = 1'b0;
        phase_nxt     = PH_SIGN;
        oct_nxt       = 1'b0;
        halt_nxt      = 1'b0;
      end else if (!halt_r) begin
        if (phase_r == PH_SIGN && (mode_r == RADIX_DEC || mode_r == RADIX_DEC_OCT) &&
            in_if.ch == CH_MINUS) begin
          // record the sign, nothing else
          neg_nxt   = 1'b1;
          phase_nxt = PH_FIRST;
        end else begin
          if (phase_r != PH_DIGITS) begin
            phase_nxt = PH_DIGITS;
            if (mode_r == RADIX_DEC_OCT && in_if.ch == CH_ZERO) begin
              oct_nxt = 1'b1;
            end
          end
          if (in_if.ch != CH_UNDERSCORE) begin
            if (dec.is_digit) begin
              acc_nxt = acc_step;
            end else begin
              halt_nxt = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= RADIX_DEC;
      acc_r       <= '0;
      neg_r       <= 1'b0;
      phase_r     <= PH_SIGN;
      oct_r       <= 1'b0;
      halt_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        mode_r <= radix_mode_t'(cfg_if.radix_mode);
      end
      acc_r       <= acc_nxt;
      neg_r       <= neg_nxt;
      phase_r     <= phase_nxt;
      oct_r       <= oct_nxt;
      halt_r      <= halt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload: hold unless a terminator loads it
  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

`ifndef SYNTHESIS
  // a terminator beat always fills the output slot
  a_term_emits: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && is_term |=> out_valid_r)
    else $error("terminator beat did not produce a result");

  // a terminator beat leaves the string state cleared
  a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && is_term |=> (acc_r == '0) && !neg_r && !oct_r && !halt_r &&
      (phase_r == PH_SIGN))
    else $error("string state not cleared after terminator");

  // a frozen value or octal selection only exists inside the digits
  a_halt_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (halt_r || oct_r) |-> (phase_r == PH_DIGITS))
    else $error("halt or octal flag outside digit phase");

  // a sign is only recorded once the sign position has passed
  a_neg_phase: assert property (@(posedge clk) disable iff (!rst_n)
    neg_r |-> (phase_r != PH_SIGN))
    else $error("minus recorded while still expecting sign");

  // a frozen string keeps its accumulator until the terminator
  a_halt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r && !(in_acc && is_term) |=> $stable(acc_r))
    else $error("accumulator moved after freeze");
`endif

endmodule

// ===== verif/rip_value_checker.sv =====
// Checker for the radix integer parser: watches the character, value and
// configuration channels, predicts each value and compares it with the block.
// Depends on rip_pkg and rip_if.
module rip_value_checker
  import rip_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  rip_in_if    in_mon,
  rip_out_if   out_mon,
  rip_cfg_if   cfg_mon,
  output int   err_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] VAL_MASK = {64{1'b1}} >> (64 - VALUE_WIDTH);

  logic [63:0]        acc;
  logic               neg;
  phase_t             ph;
  logic               oct;
  logic               halted;
  radix_mode_t        cur_mode;
  logic signed [63:0] value_q[$];
  logic signed [63:0] want;
  int                 errs = 0;

  assign err_count = errs;

  task automatic clear_string();
    acc    = '0;
    neg    = 1'b0;
    ph     = PH_SIGN;
    oct    = 1'b0;
    halted = 1'b0;
  endtask

  // Advance the string state by one character; queue a value on the terminator.
  task automatic parse_char(input logic [7:0] c);
    logic [63:0] base;
    logic [7:0]  d;
    logic        is_d;
    logic [63:0] v;
    if (c == CH_NUL) begin
      v = neg ? (64'd0 - acc) : acc;
      v &= VAL_MASK;
      if (v[VALUE_WIDTH-1]) v |= ~VAL_MASK;
      value_q.push_back(v);
      clear_string();
      return;
    end
    if (halted) return;
    if (ph == PH_SIGN) begin
      if ((cur_mode == RADIX_DEC || cur_mode == RADIX_DEC_OCT) && c == CH_MINUS) begin
        neg = 1'b1;
        ph  = PH_FIRST;
        return;
      end
      ph = PH_FIRST;
    end
    if (ph == PH_FIRST) begin
      ph = PH_DIGITS;
      if (cur_mode == RADIX_DEC_OCT && c == CH_ZERO) oct = 1'b1;
    end
    if (c == CH_UNDERSCORE) return;
    d = c - CH_ZERO;
    case (cur_mode)
      RADIX_HEX: begin
        base = 64'd16;
        is_d = 1'b1;
        if (c >= CH_ZERO && c <= CH_NINE) d = c - CH_ZERO;
        else if (c >= CH_UPPER_A && c <= CH_UPPER_F) d = c - CH_UPPER_A + 8'd10;
        else if (c >= CH_LOWER_A && c <= CH_LOWER_F) d = c - CH_LOWER_A + 8'd10;
        else is_d = 1'b0;
      end
      RADIX_BIN: begin
        base = 64'd2;
        is_d = (c == CH_ZERO || c == CH_ONE);
      end
      default: begin
        base = oct ? 64'd8 : 64'd10;
        is_d = (c >= CH_ZERO) && (c <= (oct ? CH_SEVEN : CH_NINE));
      end
    endcase
    if (!is_d) halted = 1'b1;
    else acc = (acc * base + {56'd0, d}) & VAL_MASK;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_string();
      cur_mode = RADIX_DEC;
      value_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (value_q.size() == 0) begin
          errs++;
          $display("%0t: value beat with none expected: expected none actual %0d",
                   $time, out_mon.value);
        end else begin
          want = value_q.pop_front();
          if (out_mon.value !== want) begin
            errs++;
            $display("%0t: value mismatch: expected %0d actual %0d",
                     $time, want, out_mon.value);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) parse_char(in_mon.ch);
      if (cfg_mon.valid && cfg_mon.ready) cur_mode = radix_mode_t'(cfg_mon.radix_mode);
    end
    pending <= value_q.size();
  end

endmodule

// ===== verif/tb_top.sv =====
// Top of the radix integer parser testbench: clock, reset, character strings,
// mode writes, receiver stalls and the verdict.
// Depends on rip_pkg, rip_if, radix_integer_parser_top and rip_value_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rip_pkg::*;

  localparam int VALUE_WIDTH  = VALUE_WIDTH_DEF;
  localparam int RAND_CHARS   = 1500;
  // Far above the slowest legal run: ~1600 characters, each at worst a long
  // sender gap plus a stalled output register ahead of it.
  localparam int CYCLE_LIMIT  = 400000;
  localparam int CFG_SETTLE   = 4;
  localparam int DRAIN_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst_n;
  int          err_count;
  int          pending;
  int          idle_pct  = 0;
  int          stall_pct = 0;
  int          cycle_count = 0;
  radix_mode_t tb_mode = RADIX_DEC;

  rip_in_if  in_if ();
  rip_out_if out_if ();
  rip_cfg_if cfg_if ();

  radix_integer_parser_top #(.VALUE_WIDTH(VALUE_WIDTH)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  rip_value_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_if),
    .out_mon   (out_if),
    .cfg_mon   (cfg_if),
    .err_count (err_count),
    .pending   (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: stall the value channel at random, one decision per cycle.
  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: drop the run if it hangs anywhere.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Offer one character beat, with a random gap before it, and hold it until
  // the block takes it. Valid stays high into the next beat when no gap falls.
  task automatic send_char(input logic [7:0] c);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.ch    <= c;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // Send the characters of s followed by the terminator.
  task automatic send_str(input string s);
    foreach (s[i]) send_char(s[i]);
    send_char(CH_NUL);
  endtask

  // Build and send one random string for the current mode. Most strings are
  // well formed (optional sign, optional octal prefix, digits and underscores);
  // a few carry heavy noise, and a few are long enough to wrap the value outside binary.
  task automatic send_random_string(output int n);
    int         kind;
    int         len;
    int         noise;
    int         r;
    int         v;
    logic [7:0] c;
    n     = 0;
    kind  = $urandom_range(99);
    len   = (kind < 6) ? $urandom_range(18, 26) : $urandom_range(0, 8);
    noise = (kind >= 90) ? 40 : 3;
    if ((tb_mode == RADIX_DEC || tb_mode == RADIX_DEC_OCT) && $urandom_range(3) == 0) begin
      send_char(CH_MINUS);
      n++;
    end
    if (tb_mode == RADIX_DEC_OCT && $urandom_range(1) == 1) begin
      send_char(CH_ZERO);
      n++;
    end
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(99);
      if (r < 8) begin
        c = CH_UNDERSCORE;
      end else if (r < 8 + noise) begin
        c = 8'($urandom_range(1, 255));
      end else begin
        case (tb_mode)
          RADIX_HEX: begin
            v = $urandom_range(15);
            if (v < 10) c = CH_ZERO + 8'(v);
            else c = ($urandom_range(1) ? CH_UPPER_A : CH_LOWER_A) + 8'(v - 10);
          end
          RADIX_BIN:     c = CH_ZERO + 8'($urandom_range(1));
          RADIX_DEC_OCT: c = CH_ZERO + 8'(($urandom_range(7) == 0) ? $urandom_range(9)
                                                                  : $urandom_range(7));
          default:       c = CH_ZERO + 8'($urandom_range(9));
        endcase
      end
      send_char(c);
      n++;
    end
    send_char(CH_NUL);
    n++;
  endtask

  // Write the mode register with the block idle: drop input valid, wait for
  // every outstanding value, let the pipeline settle, then send one beat.
  task automatic write_mode(input radix_mode_t m);
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (CFG_SETTLE) @(posedge clk);
    cfg_if.valid      <= 1'b1;
    cfg_if.radix_mode <= m;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    tb_mode = m;
  endtask

  initial begin
    int sent;
    int n;
    rst_n             <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.ch          <= CH_NUL;
    cfg_if.valid      <= 1'b0;
    cfg_if.radix_mode <= RADIX_DEC;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed strings: sign and underscore, lone sign, empty string, top
    // character code freezing the value, octal prefix, underscore before a
    // zero keeping decimal, hex letters of both cases, minus in hex, binary.
    write_mode(RADIX_DEC);
    send_str("-1_2");
    send_str("-");
    send_str("");
    send_str("7\3773");
    write_mode(RADIX_DEC_OCT);
    send_str("-0_17");
    send_str("_08");
    write_mode(RADIX_HEX);
    send_str("aF-9");
    write_mode(RADIX_BIN);
    send_str("10");

    // Random strings in four idling phases, each running every mode once;
    // rotate the mode order so both extremes lead a phase.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 56; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 56; end
        default: begin idle_pct = 19; stall_pct = 19; end
      endcase
      for (int k = 0; k < 4; k++) begin
        write_mode(radix_mode_t'((p * 3 + k) % 4));
        sent = 0;
        while (sent < RAND_CHARS / 16) begin
          send_random_string(n);
          sent += n;
        end
      end
    end

    // Drain: hold input low, wait for the last value, then a short tail.
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
